// ===== rtl/hsat_pkg.sv =====
// Package with shared types, constants and a SHA-256 helper for the area tag engine.
package hsat_pkg;

    localparam int KEY_WORDS = 4;
    localparam int ADDR_W    = 6;

    // Configuration register byte addresses (8-byte stride).
    localparam logic [ADDR_W-1:0] ADDR_KEY0  = 6'd0;
    localparam logic [ADDR_W-1:0] ADDR_KEY1  = 6'd8;
    localparam logic [ADDR_W-1:0] ADDR_KEY2  = 6'd16;
    localparam logic [ADDR_W-1:0] ADDR_KEY3  = 6'd24;
    localparam logic [ADDR_W-1:0] ADDR_SLOTS = 6'd32;

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5c;
    localparam logic [71:0] MAGIC = 72'h56434b5341524541_31;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        last_word;
    } in_item_t;

    typedef struct packed {
        logic [63:0] tag_word;
        logic [1:0]  tag_index;
        logic        tag_last;
    } out_item_t;

    // Byte source selection for the datapath's byte feeder.
    typedef enum logic [2:0] {
        SRC_PAD,
        SRC_HDR,
        SRC_DATA,
        SRC_FIN,
        SRC_INNER
    } src_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       init;       // load IV, clear length
        logic       feed;       // absorb one byte
        src_t       src;
        logic [5:0] idx;        // byte index within the source
        logic [7:0] padc;
        logic       save_inner; // capture chain as inner digest
        logic       lat_len;    // latch length for padding
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic       busy;       // compression running
        logic [5:0] fill;       // bytes held in block buffer
    } dp_sts_t;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/hsat_core.sv =====
// SHA-256 compression unit: one round per cycle over a 16-word schedule window.
module hsat_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [511:0]  block,
    input  logic [255:0]  chain_in,
    output logic          busy,
    output logic          done,
    output logic [255:0]  chain_out
);

    logic [31:0] w_reg [16];
    logic [31:0] s_reg [8];
    logic [5:0]  rnd_reg;
    logic        busy_reg;
    logic        fin_reg;
    logic [31:0] t1, t2, wn, s0w, s1w;

    // Round function and next schedule word.
    always_comb begin
        t1 = s_reg[7] + (hsat_pkg::rotr(s_reg[4], 6) ^ hsat_pkg::rotr(s_reg[4], 11)
             ^ hsat_pkg::rotr(s_reg[4], 25)) + ((s_reg[4] & s_reg[5]) ^ (~s_reg[4] & s_reg[6]))
             + hsat_pkg::SHA_K[rnd_reg] + w_reg[0];
        t2 = (hsat_pkg::rotr(s_reg[0], 2) ^ hsat_pkg::rotr(s_reg[0], 13)
             ^ hsat_pkg::rotr(s_reg[0], 22))
             + ((s_reg[0] & s_reg[1]) ^ (s_reg[0] & s_reg[2]) ^ (s_reg[1] & s_reg[2]));
        s0w = hsat_pkg::rotr(w_reg[1], 7) ^ hsat_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1w = hsat_pkg::rotr(w_reg[14], 17) ^ hsat_pkg::rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wn  = s1w + w_reg[9] + s0w + w_reg[0];
    end

    // Round counter and working state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            rnd_reg  <= '0;
        end else begin
            fin_reg <= !start && busy_reg && (rnd_reg == 6'd63);
            if (start) begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
                for (int i = 0; i < 16; i++) w_reg[i] <= block[511-32*i -: 32];
                for (int i = 0; i < 8; i++)  s_reg[i] <= chain_in[255-32*i -: 32];
            end else if (busy_reg) begin
                for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                w_reg[15] <= wn;
                s_reg[7] <= s_reg[6];
                s_reg[6] <= s_reg[5];
                s_reg[5] <= s_reg[4];
                s_reg[4] <= s_reg[3] + t1;
                s_reg[3] <= s_reg[2];
                s_reg[2] <= s_reg[1];
                s_reg[1] <= s_reg[0];
                s_reg[0] <= t1 + t2;
                rnd_reg  <= rnd_reg + 6'd1;
                busy_reg <= (rnd_reg != 6'd63);
            end
        end
    end

    assign busy = busy_reg | fin_reg;
    assign done = fin_reg;
    always_comb begin
        for (int i = 0; i < 8; i++) chain_out[255-32*i -: 32] = s_reg[i];
    end

endmodule

// ===== rtl/hsat_datapath.sv =====
// Datapath: byte feeder, block buffer, length counter, chain value and inner digest.
module hsat_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  hsat_pkg::dp_cmd_t   cmd,
    input  logic [255:0]        key,
    input  logic [31:0]         slot_count,
    input  logic [63:0]         data_word,
    output hsat_pkg::dp_sts_t   sts,
    output logic [255:0]        digest
);

    logic [511:0] blk_reg;
    logic [63:0]  bits_reg;
    logic [63:0]  len_reg;
    logic [255:0] chain_reg;
    logic [255:0] inner_reg;
    logic [5:0]   fill;
    logic [7:0]   byte_val;
    logic         core_start_reg;
    logic         core_busy, core_done;
    logic [255:0] core_out;

    assign fill = bits_reg[8:3];

    // Select the byte to absorb.
    always_comb begin
        case (cmd.src)
            hsat_pkg::SRC_PAD:
                byte_val = cmd.idx[5] ? cmd.padc
                         : key[255 - 8*cmd.idx[4:0] -: 8] ^ cmd.padc;
            hsat_pkg::SRC_HDR:
                byte_val = (cmd.idx < 6'd9) ? hsat_pkg::MAGIC[71 - 8*cmd.idx[3:0] -: 8]
                         : slot_count[31 - 8*(cmd.idx[3:0] - 4'd9) -: 8];
            hsat_pkg::SRC_DATA:
                byte_val = data_word[63 - 8*cmd.idx[2:0] -: 8];
            hsat_pkg::SRC_FIN:
                if (cmd.idx == 6'd0)       byte_val = 8'h80;
                else if (cmd.idx[5])       byte_val = len_reg[63 - 8*cmd.idx[2:0] -: 8];
                else                       byte_val = 8'h00;
            hsat_pkg::SRC_INNER:
                byte_val = inner_reg[255 - 8*cmd.idx[4:0] -: 8];
            default:
                byte_val = 8'h00;
        endcase
    end

    // Buffer, length and chain updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg       <= '0;
            core_start_reg <= 1'b0;
            for (int i = 0; i < 8; i++) chain_reg[255-32*i -: 32] <= hsat_pkg::SHA_IV[i];
        end else begin
            core_start_reg <= !cmd.init && cmd.feed && (fill == 6'd63);
            if (cmd.init) begin
                bits_reg <= '0;
                for (int i = 0; i < 8; i++) chain_reg[255-32*i -: 32] <= hsat_pkg::SHA_IV[i];
            end else if (cmd.feed) begin
                blk_reg[511 - 8*fill -: 8] <= byte_val;
                bits_reg <= bits_reg + 64'd8;
            end
            if (core_done) begin
                for (int i = 0; i < 8; i++)
                    chain_reg[255-32*i -: 32] <= chain_reg[255-32*i -: 32]
                                               + core_out[255-32*i -: 32];
            end
        end
    end

    // Length latch and inner digest capture need no reset.
    always_ff @(posedge aclk) begin
        if (cmd.lat_len) len_reg <= bits_reg;
        if (cmd.save_inner) inner_reg <= chain_reg;
    end

    hsat_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (core_start_reg),
        .block     (blk_reg),
        .chain_in  (chain_reg),
        .busy      (core_busy),
        .done      (core_done),
        .chain_out (core_out)
    );

    assign sts.busy = core_busy | core_start_reg;
    assign sts.fill = fill;
    assign digest   = chain_reg;

endmodule

// ===== rtl/hsat_ctrl.sv =====
// Controller: sequences header, region bytes, padding, outer hash and tag output.
module hsat_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hsat_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output hsat_pkg::out_item_t m_item,
    input  hsat_pkg::dp_sts_t   sts,
    input  logic [255:0]        digest,
    output hsat_pkg::dp_cmd_t   cmd,
    output logic [63:0]         word_out
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_IPAD, ST_HDR, ST_DATA, ST_FIN1, ST_FIN2, ST_OPAD, ST_INNER, ST_FIN3,
        ST_FIN4, ST_WAIT, ST_OUT
    } state_t;

    state_t      state_reg;
    logic [5:0]  idx_reg;
    logic [3:0]  cnt_reg;
    logic        last_reg;
    logic        hdr_done_reg;
    logic        init_pend_reg;
    logic [63:0] word_reg;
    logic [1:0]  oidx_reg;
    logic        mval_reg;
    logic [255:0] tag_reg;
    logic        feed;

    // Bytes are only fed while the compression unit is free.
    assign feed = !sts.busy;

    always_comb begin
        cmd = '0;
        cmd.idx = idx_reg;
        case (state_reg)
            ST_IPAD:  begin cmd.feed = feed; cmd.src = hsat_pkg::SRC_PAD;
                            cmd.padc = hsat_pkg::IPAD; end
            ST_OPAD:  begin cmd.feed = feed; cmd.src = hsat_pkg::SRC_PAD;
                            cmd.padc = hsat_pkg::OPAD; end
            ST_HDR:   begin cmd.feed = feed; cmd.src = hsat_pkg::SRC_HDR; end
            ST_DATA:  begin cmd.feed = feed && (idx_reg[3:0] < cnt_reg);
                            cmd.src = hsat_pkg::SRC_DATA; end
            ST_FIN2, ST_FIN4: begin cmd.feed = feed; cmd.src = hsat_pkg::SRC_FIN; end
            ST_INNER: begin cmd.feed = feed; cmd.src = hsat_pkg::SRC_INNER; end
            default:  ;
        endcase
        cmd.lat_len = (state_reg == ST_FIN1 || state_reg == ST_FIN3) && feed;
        cmd.save_inner = (state_reg == ST_OPAD) && feed && init_pend_reg;
        cmd.init = (state_reg == ST_IPAD || state_reg == ST_OPAD) && feed && init_pend_reg;
        if (cmd.init) cmd.feed = 1'b0;
    end

    assign s_ready  = (state_reg == ST_IDLE) && !mval_reg;
    assign m_valid  = mval_reg;
    assign word_out = word_reg;
    assign m_item.tag_word  = tag_reg[255 - 64*oidx_reg -: 64];
    assign m_item.tag_index = oidx_reg;
    assign m_item.tag_last  = (oidx_reg == 2'd3);

    // State, counters and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            hdr_done_reg  <= 1'b0;
            init_pend_reg <= 1'b0;
            mval_reg      <= 1'b0;
            oidx_reg      <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: if (s_valid && s_ready) begin
                    word_reg <= s_item.data_word;
                    cnt_reg  <= (s_item.byte_count > 4'd8) ? 4'd8 : s_item.byte_count;
                    last_reg <= s_item.last_word;
                    idx_reg  <= '0;
                    init_pend_reg <= !hdr_done_reg;
                    state_reg <= hdr_done_reg ? ST_DATA : ST_IPAD;
                end
                ST_IPAD: if (feed) begin
                    // First cycle only initializes; bytes follow after it.
                    if (init_pend_reg) init_pend_reg <= 1'b0;
                    else if (idx_reg == 6'd63) begin
                        idx_reg <= '0; state_reg <= ST_HDR;
                    end else idx_reg <= idx_reg + 6'd1;
                end
                ST_HDR: if (feed) begin
                    if (idx_reg == 6'd12) begin
                        idx_reg <= '0; hdr_done_reg <= 1'b1; state_reg <= ST_DATA;
                    end else idx_reg <= idx_reg + 6'd1;
                end
                ST_DATA: if (feed) begin
                    if (idx_reg[3:0] >= cnt_reg) begin
                        idx_reg   <= '0;
                        state_reg <= last_reg ? ST_FIN1 : ST_IDLE;
                    end else idx_reg <= idx_reg + 6'd1;
                end
                ST_FIN1, ST_FIN3: if (feed) begin
                    idx_reg   <= '0;
                    state_reg <= (state_reg == ST_FIN1) ? ST_FIN2 : ST_FIN4;
                end
                ST_FIN2, ST_FIN4: if (feed) begin
                    // 0x80, zeros to fill 56, then eight length bytes (idx 32..39).
                    if (idx_reg[5] && idx_reg[2:0] == 3'd7) begin
                        idx_reg   <= '0;
                        if (state_reg == ST_FIN2) init_pend_reg <= 1'b1;
                        state_reg <= (state_reg == ST_FIN2) ? ST_OPAD : ST_WAIT;
                    end else if (!idx_reg[5] && idx_reg != 6'd0 && sts.fill == 6'd55) begin
                        idx_reg <= 6'd32;
                    end else if (idx_reg == 6'd0 && sts.fill == 6'd55) begin
                        idx_reg <= 6'd32;
                    end else if (idx_reg == 6'd0) begin
                        idx_reg <= 6'd1;
                    end else if (idx_reg[5]) begin
                        idx_reg <= idx_reg + 6'd1;
                    end
                end
                ST_OPAD: if (feed) begin
                    // The first cycle saves the inner digest and restarts the chain.
                    if (init_pend_reg) init_pend_reg <= 1'b0;
                    else if (idx_reg == 6'd63) begin
                        idx_reg <= '0; state_reg <= ST_INNER;
                    end else idx_reg <= idx_reg + 6'd1;
                end
                ST_INNER: if (feed) begin
                    if (idx_reg == 6'd31) begin
                        idx_reg <= '0; state_reg <= ST_FIN3;
                    end else idx_reg <= idx_reg + 6'd1;
                end
                ST_WAIT: if (feed) begin
                    tag_reg   <= digest;
                    oidx_reg  <= '0;
                    mval_reg  <= 1'b1;
                    hdr_done_reg <= 1'b0;
                    state_reg <= ST_OUT;
                end
                ST_OUT: if (m_ready) begin
                    oidx_reg <= oidx_reg + 2'd1;
                    if (oidx_reg == 2'd3) begin
                        mval_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/hmac_sha256_area_tag.sv =====
// Top level of the HMAC-SHA256 area tag engine with its configuration registers.
// The engine absorbs region bytes one per cycle, while no compression runs, into a
// 64-byte block and runs the SHA-256 compression at one round per cycle on each full
// block. The first word of a message also absorbs the inner pad and header, and the
// last word adds padding and the outer hash before the four tag words are offered in
// order, index 0 first. No clearing pass follows reset.
module hmac_sha256_area_tag (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  hsat_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output hsat_pkg::out_item_t  m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [hsat_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    logic [63:0] key_reg [hsat_pkg::KEY_WORDS];
    logic [31:0] slots_reg;
    logic [255:0] key_flat;
    logic [63:0] word;
    logic [255:0] digest;
    hsat_pkg::dp_cmd_t cmd;
    hsat_pkg::dp_sts_t sts;
    logic wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < hsat_pkg::KEY_WORDS; i++) key_reg[i] <= '0;
            slots_reg <= '0;
        end else if (wr) begin
            case (paddr)
                hsat_pkg::ADDR_KEY0:  key_reg[0] <= pwdata;
                hsat_pkg::ADDR_KEY1:  key_reg[1] <= pwdata;
                hsat_pkg::ADDR_KEY2:  key_reg[2] <= pwdata;
                hsat_pkg::ADDR_KEY3:  key_reg[3] <= pwdata;
                hsat_pkg::ADDR_SLOTS: slots_reg  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (paddr)
            hsat_pkg::ADDR_KEY0:  prdata = key_reg[0];
            hsat_pkg::ADDR_KEY1:  prdata = key_reg[1];
            hsat_pkg::ADDR_KEY2:  prdata = key_reg[2];
            hsat_pkg::ADDR_KEY3:  prdata = key_reg[3];
            hsat_pkg::ADDR_SLOTS: prdata = {32'd0, slots_reg};
            default:              prdata = '0;
        endcase
    end

    assign key_flat = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};

    hsat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_data),
        .sts      (sts),
        .digest   (digest),
        .cmd      (cmd),
        .word_out (word)
    );

    hsat_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .key        (key_flat),
        .slot_count (slots_reg),
        .data_word  (word),
        .sts        (sts),
        .digest     (digest)
    );

    // Input is only taken while no tag transfer is pending.
    assert property (@(posedge aclk) disable iff (!aresetn) m_valid |-> !s_ready)
        else $error("input accepted while tag pending");

    // Tag index advances by one after each result transfer that is not the last.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.tag_last) |=>
        (m_valid && m_data.tag_index == $past(m_data.tag_index) + 2'd1))
        else $error("tag index skipped");

    // Bytes are never absorbed while a compression runs.
    assert property (@(posedge aclk) disable iff (!aresetn) cmd.feed |-> !sts.busy)
        else $error("byte fed during compression");

endmodule
